### rtl/gqi_pkg.sv
`timescale 1ns / 1ps
package gqi_pkg;

  localparam int QW = 32;
  localparam int RW = 24;
  localparam int SW = 58;
  localparam int DW = 16;
  localparam int NT = 12;

  localparam logic signed [QW-1:0] Q_ONE   = 32'sh4000_0000;
  localparam logic signed [QW-1:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic [DW-1:0]        DT_RESET = 16'd10486;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PROD  = 7'b0000010,
    ST_SCALE = 7'b0000100,
    ST_SQ    = 7'b0001000,
    ST_SQRT  = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_e;

  typedef struct packed {
    logic [1:0] tgt;
    logic [1:0] qi;
    logic [1:0] wj;
    logic       neg;
  } term_t;

  // cross terms of q (x) (0, w)
  localparam term_t TERMS [NT] = '{
    '{2'd0, 2'd1, 2'd0, 1'b1},
    '{2'd0, 2'd2, 2'd1, 1'b1},
    '{2'd0, 2'd3, 2'd2, 1'b1},
    '{2'd1, 2'd0, 2'd0, 1'b0},
    '{2'd1, 2'd2, 2'd2, 1'b0},
    '{2'd1, 2'd3, 2'd1, 1'b1},
    '{2'd2, 2'd0, 2'd1, 1'b0},
    '{2'd2, 2'd1, 2'd2, 1'b1},
    '{2'd2, 2'd3, 2'd0, 1'b0},
    '{2'd3, 2'd0, 2'd2, 1'b0},
    '{2'd3, 2'd1, 2'd1, 1'b0},
    '{2'd3, 2'd2, 2'd0, 1'b1}
  };

endpackage

### rtl/gyro_quaternion_integrator_unit.sv
`timescale 1ns / 1ps
// Gyro quaternion integrator. Each accepted item (x, y, z rates) advances the
// stored Q1.30 orientation by one Euler step of 0.5*q(x)(0,w)*dt, saturates,
// renormalizes by the integer square root of the sum of squares and returns
// the new quaternion as one item. One shared 33x33 multiplier handles the 12
// cross terms, the 8 dt scalings and the 4 squares; the root is found one bit
// a cycle and each component is divided one quotient bit a cycle. When the
// sum of squares is zero the root and the four divisions are skipped. The
// finished item waits while the previous result is held on out_stall_i. No
// new item is taken until the block is idle again. time_step may be written
// whenever the block is idle.
module gyro_quaternion_integrator_unit
  import gqi_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 time_step_we_i,
  input  logic [DW-1:0]        time_step_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [RW-1:0] rate_x_i,
  input  logic signed [RW-1:0] rate_y_i,
  input  logic signed [RW-1:0] rate_z_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [QW-1:0] quat_w_o,
  output logic signed [QW-1:0] quat_x_o,
  output logic signed [QW-1:0] quat_y_o,
  output logic signed [QW-1:0] quat_z_o
);

  state_e state_q;
  logic [4:0] cnt_q;
  logic [1:0] comp_q;
  logic [DW-1:0] dt_q;
  logic signed [RW-1:0] w_q [3];
  logic signed [QW-1:0] q_q [4];
  logic signed [SW-1:0] s_q [4];
  logic signed [QW-1:0] v_q [4];
  logic signed [45:0] hp_q;
  logic signed [65:0] prod_q;
  logic [63:0] sum_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [31:0] rd_q;
  logic [29:0] quo_q;
  logic out_valid_q;
  logic signed [QW-1:0] out_q [4];

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  term_t t_iss, t_acc;
  logic signed [SW-1:0] s_cur;
  logic [1:0] cidx;
  logic signed [75:0] tot;
  logic signed [39:0] u;
  logic signed [QW-1:0] v_sat;
  logic [63:0] sum_n;
  logic [35:0] rem2, trial;
  logic [31:0] vabs;
  logic [32:0] cand;
  logic [33:0] diff;
  logic ge;
  logic [30:0] quo_f;
  logic signed [QW-1:0] qres;

  always_comb begin
    t_iss = TERMS[(cnt_q < 5'd12) ? cnt_q[3:0] : 4'd0];
    t_acc = TERMS[(cnt_q != 5'd0 && cnt_q <= 5'd12) ? (cnt_q[3:0] - 4'd1) : 4'd0];
    s_cur = s_q[cnt_q[2:1]];
    mul_a = '0;
    mul_b = '0;
    if (state_q == ST_PROD) begin
      mul_a = 33'(q_q[t_iss.qi]);
      mul_b = 33'(w_q[t_iss.wj]);
    end else if (state_q == ST_SCALE) begin
      mul_a = cnt_q[0] ? $signed({4'd0, s_cur[28:0]}) : 33'($signed(s_cur[SW-1:29]));
      mul_b = $signed({17'd0, dt_q});
    end else if (state_q == ST_SQ) begin
      mul_a = 33'(v_q[cnt_q[1:0]]);
      mul_b = 33'(v_q[cnt_q[1:0]]);
    end
  end

  assign prod = mul_a * mul_b;

  // dt scaling, rounding and saturation
  always_comb begin
    cidx = 2'(cnt_q[3:1] - 4'd1);
    tot = 76'($signed({hp_q, 29'd0})) + $signed({31'd0, prod_q[44:0]})
        + 76'sd68719476736;
    u = 40'(q_q[cidx]) + 40'($signed(tot[75:37]));
    if (u > 40'sd2147483647) begin
      v_sat = SAT_MAX;
    end else if (u < -40'sd2147483647) begin
      v_sat = -SAT_MAX;
    end else begin
      v_sat = u[31:0];
    end
  end

  always_comb begin
    sum_n = sum_q + prod_q[63:0];
    rem2  = {rem_q, sum_q[63:62]};
    trial = {2'd0, root_q, 2'b01};
    vabs  = v_q[comp_q][31] ? 32'(-v_q[comp_q]) : v_q[comp_q];
    cand  = (cnt_q == 5'd0) ? {2'd0, vabs[30:0]} : {rd_q, 1'b0};
    diff  = {1'b0, cand} - {2'd0, root_q};
    ge    = !diff[33];
    quo_f = {quo_q, ge};
    qres  = v_q[comp_q][31] ? -$signed({1'b0, quo_f}) : $signed({1'b0, quo_f});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      comp_q      <= '0;
      dt_q        <= DT_RESET;
      q_q[0]      <= Q_ONE;
      q_q[1]      <= '0;
      q_q[2]      <= '0;
      q_q[3]      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (time_step_we_i) begin
        dt_q <= time_step_i;
      end
      if (out_valid_q && !out_stall_i && state_q != ST_FIN) begin
        out_valid_q <= 1'b0;
      end
      prod_q <= prod;
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            w_q[0] <= rate_x_i;
            w_q[1] <= rate_y_i;
            w_q[2] <= rate_z_i;
            for (int i = 0; i < 4; i++) s_q[i] <= '0;
            cnt_q   <= '0;
            state_q <= ST_PROD;
          end
        end
        ST_PROD: begin
          if (cnt_q != 5'd0) begin
            s_q[t_acc.tgt] <= t_acc.neg ? s_q[t_acc.tgt] - $signed(prod_q[SW-1:0])
                                        : s_q[t_acc.tgt] + $signed(prod_q[SW-1:0]);
          end
          if (cnt_q == 5'd12) begin
            cnt_q   <= '0;
            state_q <= ST_SCALE;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        ST_SCALE: begin
          if (cnt_q[0]) begin
            hp_q <= $signed(prod_q[45:0]);
          end else if (cnt_q != 5'd0) begin
            v_q[cidx] <= v_sat;
          end
          if (cnt_q == 5'd8) begin
            cnt_q   <= '0;
            sum_q   <= '0;
            state_q <= ST_SQ;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        ST_SQ: begin
          if (cnt_q == 5'd4) begin
            cnt_q  <= '0;
            rem_q  <= '0;
            root_q <= '0;
            if (sum_n == 64'd0) begin
              q_q[0]  <= Q_ONE;
              q_q[1]  <= '0;
              q_q[2]  <= '0;
              q_q[3]  <= '0;
              state_q <= ST_FIN;
            end else begin
              sum_q   <= sum_n;
              state_q <= ST_SQRT;
            end
          end else begin
            if (cnt_q != 5'd0) begin
              sum_q <= sum_n;
            end
            cnt_q <= cnt_q + 5'd1;
          end
        end
        ST_SQRT: begin
          if (rem2 >= trial) begin
            rem_q  <= 34'(rem2 - trial);
            root_q <= {root_q[30:0], 1'b1};
          end else begin
            rem_q  <= rem2[33:0];
            root_q <= {root_q[30:0], 1'b0};
          end
          sum_q <= {sum_q[61:0], 2'b00};
          if (cnt_q == 5'd31) begin
            cnt_q   <= '0;
            comp_q  <= '0;
            state_q <= ST_DIV;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        ST_DIV: begin
          rd_q  <= ge ? diff[31:0] : cand[31:0];
          quo_q <= quo_f[29:0];
          if (cnt_q == 5'd30) begin
            q_q[comp_q] <= qres;
            cnt_q       <= '0;
            if (comp_q == 2'd3) begin
              state_q <= ST_FIN;
            end else begin
              comp_q <= comp_q + 2'd1;
            end
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        ST_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            for (int i = 0; i < 4; i++) out_q[i] <= q_q[i];
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign quat_w_o    = out_q[0];
  assign quat_x_o    = out_q[1];
  assign quat_y_o    = out_q[2];
  assign quat_z_o    = out_q[3];

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == ST_PROD)
    else $error("accepted item did not start the product phase");

  a_root_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> root_q != '0)
    else $error("division by a zero norm");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> quat_w_o <= 32'sd1073741824 && quat_w_o >= -32'sd1073741824)
    else $error("normalized component outside unit range");

endmodule

### test/tb.sv
`timescale 1ns / 1ps
module tb
  import gqi_pkg::*;
();

  typedef struct {
    logic signed [QW-1:0] w;
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
  } quat_t;

  class attitude_board;
    longint        att [4];
    logic [DW-1:0] dt;
    quat_t         pending_q [$];
    int            mismatches;
    int            results_seen;

    function new();
      dt = DT_RESET;
      att[0] = longint'(Q_ONE);
      att[1] = 0;
      att[2] = 0;
      att[3] = 0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function longint unsigned root64(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function void note_rates(logic signed [RW-1:0] rx, logic signed [RW-1:0] ry,
                             logic signed [RW-1:0] rz);
      longint               wx, wy, wz;
      longint               s [4];
      longint               u [4];
      logic signed [127:0]  prod;
      longint unsigned      sumsq;
      longint               nrm;
      quat_t                e;
      wx = longint'(rx);
      wy = longint'(ry);
      wz = longint'(rz);
      s[0] = -att[1] * wx - att[2] * wy - att[3] * wz;
      s[1] = att[0] * wx + att[2] * wz - att[3] * wy;
      s[2] = att[0] * wy - att[1] * wz + att[3] * wx;
      s[3] = att[0] * wz + att[1] * wy - att[2] * wx;
      sumsq = 0;
      for (int i = 0; i < 4; i++) begin
        prod = 128'(signed'(s[i])) * 128'(signed'({1'b0, dt}));
        prod = (prod + (128'sd1 <<< 36)) >>> 37;
        u[i] = att[i] + longint'(prod);
        if (u[i] > 64'sd2147483647) u[i] = 64'sd2147483647;
        if (u[i] < -64'sd2147483647) u[i] = -64'sd2147483647;
        sumsq = sumsq + longint'(u[i] * u[i]);
      end
      if (sumsq == 0) begin
        att[0] = longint'(Q_ONE);
        att[1] = 0;
        att[2] = 0;
        att[3] = 0;
      end else begin
        nrm = longint'(root64(sumsq));
        for (int i = 0; i < 4; i++) begin
          att[i] = longint'(32'(signed'((u[i] * 64'sd1073741824) / nrm)));
        end
      end
      e.w = 32'(att[0]);
      e.x = 32'(att[1]);
      e.y = 32'(att[2]);
      e.z = 32'(att[3]);
      pending_q.push_back(e);
    endfunction

    function void check_quat(quat_t got);
      quat_t e;
      results_seen++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result w=%0d x=%0d y=%0d z=%0d", got.w, got.x, got.y, got.z);
        return;
      end
      e = pending_q.pop_front();
      if (got.w !== e.w || got.x !== e.x || got.y !== e.y || got.z !== e.z) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch result %0d: exp w=%0d x=%0d y=%0d z=%0d got w=%0d x=%0d y=%0d z=%0d",
                   results_seen, e.w, e.x, e.y, e.z, got.w, got.x, got.y, got.z);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 dt_we = 1'b0;
  logic [DW-1:0]        dt_val = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [RW-1:0] rate_x = '0;
  logic signed [RW-1:0] rate_y = '0;
  logic signed [RW-1:0] rate_z = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  quat_t                q_out;
  int                   tx_pct = 0;
  int                   rx_pct = 0;
  int                   items_sent = 0;
  attitude_board        sb;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  gyro_quaternion_integrator_unit u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .time_step_we_i (dt_we),
    .time_step_i    (dt_val),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .rate_x_i       (rate_x),
    .rate_y_i       (rate_y),
    .rate_z_i       (rate_z),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .quat_w_o       (q_out.w),
    .quat_x_o       (q_out.x),
    .quat_y_o       (q_out.y),
    .quat_z_o       (q_out.z)
  );

  // result side: check on accept, then pick next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_quat(q_out);
    out_stall <= ($urandom_range(99) < rx_pct);
  end

  task automatic send_rates(logic signed [RW-1:0] rx, logic signed [RW-1:0] ry,
                            logic signed [RW-1:0] rz);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rate_x <= rx;
    rate_y <= ry;
    rate_z <= rz;
    do @(posedge clk); while (in_stall);
    sb.note_rates(rx, ry, rz);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_dt(logic [DW-1:0] v);
    drain();
    dt_we <= 1'b1;
    dt_val <= v;
    @(posedge clk);
    sb.dt = v;
    dt_we <= 1'b0;
  endtask

  function automatic logic signed [RW-1:0] pick_rate();
    case ($urandom_range(9))
      0: return RW'($urandom);
      1: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
      2, 3, 4: return RW'($signed($urandom_range(2000000)) - 1000000);
      default: return RW'($signed($urandom_range(200000)) - 100000);
    endcase
  endfunction

  task automatic random_items(int n);
    for (int i = 0; i < n; i++) send_rates(pick_rate(), pick_rate(), pick_rate());
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_pct = 22;
    rx_pct = 72;
    send_rates(0, 0, 0);
    send_rates(24'sh7fffff, 0, 0);
    send_rates(0, 24'sh7fffff, 0);
    send_rates(0, 0, 24'sh7fffff);
    send_rates(24'sh800000, 0, 0);
    send_rates(0, 24'sh800000, 0);
    send_rates(0, 0, 24'sh800000);
    send_rates(24'sh7fffff, 24'sh7fffff, 24'sh7fffff);
    send_rates(24'sh800000, 24'sh800000, 24'sh800000);
    send_rates(-1, -1, -1);
    write_dt(16'hffff);
    send_rates(24'sh7fffff, 24'sh800000, 24'sh7fffff);
    send_rates(24'sh800000, 24'sh7fffff, 24'sh800000);
    send_rates(24'sh7fffff, 24'sh7fffff, 24'sh800000);
    write_dt(16'd0);
    send_rates(24'sh7fffff, 24'sh800000, 24'sh7fffff);
    send_rates(12345, -54321, 999);
    write_dt(16'd1);
    send_rates(24'sh7fffff, 24'sh7fffff, 24'sh7fffff);
    send_rates(1, -1, 1);
    write_dt(DT_RESET);
    random_items(500);

    write_dt(16'(($urandom_range(65534)) + 1));
    tx_pct = 72;
    rx_pct = 22;
    random_items(250);
    write_dt(16'hffff);
    random_items(250);

    write_dt(16'd1);
    tx_pct = 0;
    rx_pct = 0;
    random_items(150);
    write_dt(16'(($urandom_range(65534)) + 1));
    random_items(380);

    drain();
    $display("run: %0d gyro items through three idle mixes, dt from 0 to 65535", items_sent);
    $display("run: %0d quaternions checked, %0d mismatches", sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
